>>> src/pfmt_pkg.sv
`default_nettype none
package pfmt_pkg;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int VAL_W         = 32;
  localparam int NDIG          = 11;

  localparam int FLB_MINUS = 0;
  localparam int FLB_PLUS  = 1;
  localparam int FLB_ZERO  = 2;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_CHAR = 3'd1;
  localparam logic [2:0] ACT_DEC  = 3'd2;
  localparam logic [2:0] ACT_OCT  = 3'd3;
  localparam logic [2:0] ACT_HEX  = 3'd4;

  typedef struct packed {
    logic [7:0]       fmt_char;
    logic [VAL_W-1:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       is_signed;
    logic       upper;
  } action_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic gen;
    logic plan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic gen_done;
    logic emit_last;
    logic slot_free;
    logic is_dec;
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else if (upper) begin
      r = 8'h41 + {4'h0, d - 4'd10};
    end else begin
      r = 8'h61 + {4'h0, d - 4'd10};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/pfmt_parse.sv
`default_nettype none
module pfmt_parse
  import pfmt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  in_item_t      in_data,
  output action_t       action,
  output logic [2:0]    spec_flags,
  output logic [WW-1:0] field_width
);

  localparam logic [2:0] PH_COPY  = 3'd0;
  localparam logic [2:0] PH_FLAGS = 3'd1;
  localparam logic [2:0] PH_WIDTH = 3'd2;
  localparam logic [2:0] PH_PREC  = 3'd3;
  localparam logic [2:0] PH_TYPE  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7A;

  logic [2:0]    parse_phase;
  logic [2:0]    phase_next;
  logic [2:0]    flags_next;
  logic [WW-1:0] width_next;
  logic [7:0]    c;
  logic          is_digit;
  logic          is_flag;
  logic          is_len;
  logic          to_width;
  logic          to_type;
  logic [3:0]    dval;
  logic [WW+3:0] wsum;

  always_comb begin
    c        = in_data.fmt_char;
    is_digit = (c >= CH_0) && (c <= CH_9);
    dval     = c[3:0];
    is_flag  = c inside {CH_MINUS, CH_PLUS, CH_0, CH_SPACE, CH_HASH};
    is_len   = c inside {CH_H, CH_L, CH_UP_L, CH_Z, CH_J, CH_T};
    to_width = ((parse_phase == PH_FLAGS) && !is_flag) || (parse_phase == PH_WIDTH);
    to_type  = (to_width && !is_digit && (c != CH_DOT)) ||
               ((parse_phase == PH_PREC) && !is_digit) || (parse_phase == PH_TYPE);
    wsum     = (WW+4)'(field_width) * (WW+4)'(4'd10) + (WW+4)'(dval);

    phase_next = parse_phase;
    flags_next = spec_flags;
    width_next = field_width;
    action     = '{kind: ACT_NONE, ch: CH_NUL, is_signed: 1'b0, upper: 1'b0};

    if (c == CH_NUL) begin
      phase_next  = PH_COPY;
      flags_next  = 3'b000;
      width_next  = '0;
      action.kind = ACT_CHAR;
    end else if (to_type) begin
      if (is_len) begin
        phase_next = PH_TYPE;
      end else begin
        phase_next = PH_COPY;
        case (c)
          CH_D, CH_I: begin
            action.kind      = ACT_DEC;
            action.is_signed = 1'b1;
          end
          CH_U:    action.kind = ACT_DEC;
          CH_O:    action.kind = ACT_OCT;
          CH_X:    action.kind = ACT_HEX;
          CH_UP_X: begin
            action.kind  = ACT_HEX;
            action.upper = 1'b1;
          end
          CH_C: begin
            action.kind = ACT_CHAR;
            action.ch   = in_data.arg_value[7:0];
          end
          CH_PCT: begin
            action.kind = ACT_CHAR;
            action.ch   = CH_PCT;
          end
          default: ;
        endcase
      end
    end else if (to_width) begin
      if (is_digit) begin
        phase_next = PH_WIDTH;
        width_next = (wsum > (WW+4)'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : wsum[WW-1:0];
      end else begin
        phase_next = PH_PREC;
      end
    end else if (parse_phase == PH_FLAGS) begin
      case (c)
        CH_MINUS: flags_next[FLB_MINUS] = 1'b1;
        CH_PLUS:  flags_next[FLB_PLUS]  = 1'b1;
        CH_0:     flags_next[FLB_ZERO]  = 1'b1;
        default: ;
      endcase
    end else if (parse_phase == PH_PREC) begin
      phase_next = PH_PREC;
    end else if (c == CH_PCT) begin
      phase_next = PH_FLAGS;
      flags_next = 3'b000;
      width_next = '0;
    end else begin
      phase_next  = PH_COPY;
      action.kind = ACT_CHAR;
      action.ch   = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_COPY;
      spec_flags  <= 3'b000;
      field_width <= '0;
    end else if (accept) begin
      parse_phase <= phase_next;
      spec_flags  <= flags_next;
      field_width <= width_next;
    end
  end

endmodule
`default_nettype wire

>>> src/pfmt_ctrl.sv
`default_nettype none
module pfmt_ctrl
  import pfmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] act_kind,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_GEN  = 3'd2;
  localparam logic [2:0] ST_PLAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.load   = accept;
    cmd.mul    = (state == ST_MUL);
    cmd.gen    = (state == ST_GEN);
    cmd.plan   = (state == ST_PLAN);
    cmd.emit   = (state == ST_EMIT) && stat.slot_free;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act_kind)
            ACT_CHAR:         state_next = ST_EMIT;
            ACT_DEC:          state_next = ST_MUL;
            ACT_OCT, ACT_HEX: state_next = ST_GEN;
            default:          state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_next = ST_GEN;
      ST_GEN: begin
        if (stat.gen_done) begin
          state_next = ST_PLAN;
        end else if (stat.is_dec) begin
          state_next = ST_MUL;
        end
      end
      ST_PLAN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.slot_free && stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> src/pfmt_dp.sv
`default_nettype none
module pfmt_dp
  import pfmt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  action_t          action,
  input  logic [VAL_W-1:0] arg_value,
  input  logic [2:0]       spec_flags,
  input  logic [WW-1:0]    field_width,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [31:0] RECIP10  = 32'hCCCCCCCD;

  logic [VAL_W-1:0]   val;
  logic [2*VAL_W-1:0] prod;
  logic [2:0]         kind;
  logic               upper;
  logic [3:0]         digs [NDIG];
  logic [3:0]         ndig;
  logic               nsign;
  logic [7:0]         sgn_char;
  logic               mode_minus;
  logic               mode_zero;
  logic [WW-1:0]      width_r;
  logic [WW-1:0]      tot;
  logic [WW-1:0]      pad;
  logic [WW-1:0]      pos;

  logic [28:0]        q;
  logic [3:0]         q10_lo;
  logic [3:0]         dig;
  logic [VAL_W-1:0]   vnext;
  logic               neg;
  logic [WW-1:0]      total;
  logic [WW-1:0]      sn;
  logic [WW-1:0]      nd;
  logic [WW-1:0]      didx;
  logic [7:0]         emit_ch;
  logic               use_dig;

  always_comb begin
    q      = prod[63:35];
    q10_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
    case (kind)
      ACT_DEC: begin
        dig   = val[3:0] - q10_lo;
        vnext = {3'b000, q};
      end
      ACT_OCT: begin
        dig   = {1'b0, val[2:0]};
        vnext = val >> 3;
      end
      default: begin
        dig   = val[3:0];
        vnext = val >> 4;
      end
    endcase
    neg   = action.is_signed && arg_value[VAL_W-1];
    sn    = WW'(nsign);
    nd    = WW'(ndig);
    total = nd + sn;

    use_dig = 1'b0;
    emit_ch = CH_SPACE;
    didx    = tot - pos - WW'(1);
    if (mode_minus) begin
      if (pos < sn) begin
        emit_ch = sgn_char;
      end else if (pos < sn + nd) begin
        use_dig = 1'b1;
        didx    = sn + nd - pos - WW'(1);
      end
    end else if (mode_zero) begin
      if (pos < sn) begin
        emit_ch = sgn_char;
      end else if (pos < sn + pad) begin
        emit_ch = CH_0;
      end else begin
        use_dig = 1'b1;
      end
    end else begin
      if (pos < pad) begin
        emit_ch = CH_SPACE;
      end else if (pos < pad + sn) begin
        emit_ch = sgn_char;
      end else begin
        use_dig = 1'b1;
      end
    end
    if (use_dig) begin
      emit_ch = digit_char(digs[didx[3:0]], upper);
    end

    stat.gen_done  = (vnext == '0);
    stat.emit_last = (pos == tot - WW'(1));
    stat.slot_free = !out_valid || out_ready;
    stat.is_dec    = (kind == ACT_DEC);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= action.kind;
      upper   <= action.upper;
      ndig    <= 4'd0;
      pos     <= '0;
      width_r <= field_width;
      if (action.kind == ACT_CHAR) begin
        sgn_char   <= action.ch;
        nsign      <= 1'b1;
        tot        <= WW'(1);
        pad        <= '0;
        mode_minus <= 1'b0;
        mode_zero  <= 1'b0;
      end else begin
        val        <= neg ? (~arg_value + VAL_W'(1)) : arg_value;
        nsign      <= action.is_signed && (neg || spec_flags[FLB_PLUS]);
        sgn_char   <= neg ? CH_MINUS : CH_PLUS;
        mode_minus <= spec_flags[FLB_MINUS];
        mode_zero  <= spec_flags[FLB_ZERO];
      end
    end
    if (cmd.mul) begin
      prod <= (2*VAL_W)'(val) * (2*VAL_W)'(RECIP10);
    end
    if (cmd.gen) begin
      digs[ndig] <= dig;
      ndig       <= ndig + 4'd1;
      val        <= vnext;
    end
    if (cmd.plan) begin
      if (width_r > total) begin
        tot <= width_r;
        pad <= width_r - total;
      end else begin
        tot <= total;
        pad <= '0;
      end
    end
    if (cmd.emit) begin
      pos      <= pos + WW'(1);
      out_data <= '{out_char: emit_ch, last_of_run: stat.emit_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/printf_format_integer_formatter.sv
`default_nettype none
// printf-style formatter fed one format byte (plus its argument word) per transfer.
// A byte that emits nothing leaves the input ready for the next byte. A copied
// byte, %c, %% or the terminating zero is accepted and then sent as one output byte.
// Integer conversions build digits least significant first in a digit buffer:
// hex and octal at one digit per cycle, decimal through a registered multiply by
// the reciprocal of ten, then a planning state; output then streams at one byte per
// cycle while the output register is free, max(width, digits + sign) bytes in all.
// The input is taken again as soon as the final byte sits in the output register.
module printf_format_integer_formatter
  import pfmt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic          accept;
  action_t       action;
  logic [2:0]    spec_flags;
  logic [WW-1:0] field_width;
  dp_cmd_t       cmd;
  dp_stat_t      stat;

  assign accept = in_valid && in_ready;

  pfmt_parse #(.MAX_WIDTH(MAX_WIDTH)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_data     (in_data),
    .action      (action),
    .spec_flags  (spec_flags),
    .field_width (field_width)
  );

  pfmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .act_kind (action.kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  pfmt_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .arg_value   (in_data.arg_value),
    .spec_flags  (spec_flags),
    .field_width (field_width),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
